// ----- rtl/shape_pair_penetration_depth_core_defines.svh -----
// Assertion macros for the shape pair penetration depth core
`ifndef SHAPE_PAIR_PENETRATION_DEPTH_CORE_DEFINES_SVH
`define SHAPE_PAIR_PENETRATION_DEPTH_CORE_DEFINES_SVH

// same-cycle implication
`define SPP_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("spp: same-cycle check failed");

// next-cycle implication
`define SPP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("spp: next-cycle check failed");

`endif

// ----- rtl/spp_pkg.sv -----
// Types and constants shared by the shape pair penetration depth core
package spp_pkg;

   localparam int CoordW = 32;
   localparam int SizeW  = 31;
   localparam int EdgeW  = 34;   // 2*centre +/- size, Q.17
   localparam int OvW    = 35;   // edge differences
   localparam int DepthW = 32;
   localparam int RootW  = 32;
   localparam int SqW    = 64;
   localparam int RemW   = 36;
   localparam int QDepth = 2;
   localparam int QPtrW  = $clog2(QDepth);
   localparam int QCntW  = $clog2(QDepth + 1);

   typedef enum logic [1:0] {
      FUNC_RR = 2'd0,
      FUNC_CC = 2'd1,
      FUNC_RC = 2'd2,
      FUNC_CR = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      KIND_RR = 2'd0,
      KIND_CC = 2'd1,
      KIND_RC = 2'd2
   } kind_type;

   // classified item; for rect-circle, A is the rect and B the circle
   typedef struct packed {
      kind_type                  kind;
      logic signed [EdgeW-1:0]   a_lo_x;
      logic signed [EdgeW-1:0]   a_hi_x;
      logic signed [EdgeW-1:0]   a_lo_y;
      logic signed [EdgeW-1:0]   a_hi_y;
      logic signed [EdgeW-1:0]   b_lo_x;
      logic signed [EdgeW-1:0]   b_hi_x;
      logic signed [EdgeW-1:0]   b_lo_y;
      logic signed [EdgeW-1:0]   b_hi_y;
      logic signed [CoordW-1:0]  a_x;
      logic signed [CoordW-1:0]  a_y;
      logic signed [CoordW-1:0]  b_x;
      logic signed [CoordW-1:0]  b_y;
      logic [SizeW-1:0]          a_r;
      logic [SizeW-1:0]          b_r;
   } entry_type;

   // side data that rides along the square root pipe
   typedef struct packed {
      kind_type           kind;
      logic               hit;
      logic [DepthW-1:0]  lim;
      logic [SizeW-1:0]   radius;
      logic [DepthW-1:0]  rr_depth;
   } tag_type;

   typedef struct packed {
      logic              not_empty;
      logic              full;
      logic [QCntW-1:0]  count;
   } q_status_type;

   function automatic logic [OvW-1:0] mag(input logic signed [OvW-1:0] v);
      mag = v[OvW-1] ? OvW'(-v) : OvW'(v);
   endfunction

endpackage

// ----- rtl/spp_ifs.sv -----
// Valid/ready channel interfaces for the request and response sides
interface spp_req_if;
   import spp_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [1:0]                func;
   logic signed [CoordW-1:0]  a_x;
   logic signed [CoordW-1:0]  a_y;
   logic [SizeW-1:0]          a_width_or_radius;
   logic [SizeW-1:0]          a_height;
   logic signed [CoordW-1:0]  b_x;
   logic signed [CoordW-1:0]  b_y;
   logic [SizeW-1:0]          b_width_or_radius;
   logic [SizeW-1:0]          b_height;
   modport source (output valid, func, a_x, a_y, a_width_or_radius, a_height,
                   b_x, b_y, b_width_or_radius, b_height, input ready);
   modport sink (input valid, func, a_x, a_y, a_width_or_radius, a_height,
                 b_x, b_y, b_width_or_radius, b_height, output ready);
endinterface

interface spp_rsp_if;
   import spp_pkg::*;
   logic               valid;
   logic               ready;
   logic               hit;
   logic [DepthW-1:0]  depth;
   modport source (output valid, hit, depth, input ready);
   modport sink (input valid, hit, depth, output ready);
endinterface

// ----- rtl/spp_front.sv -----
// Front end: classifies the pair, swaps circle-rect, forms Q.17 edges
module spp_front (
   input  logic [1:0]                        func,
   input  logic signed [spp_pkg::CoordW-1:0] a_x,
   input  logic signed [spp_pkg::CoordW-1:0] a_y,
   input  logic [spp_pkg::SizeW-1:0]         a_w,
   input  logic [spp_pkg::SizeW-1:0]         a_h,
   input  logic signed [spp_pkg::CoordW-1:0] b_x,
   input  logic signed [spp_pkg::CoordW-1:0] b_y,
   input  logic [spp_pkg::SizeW-1:0]         b_w,
   input  logic [spp_pkg::SizeW-1:0]         b_h,
   output spp_pkg::entry_type                entry
);
   import spp_pkg::*;

   logic                     swap;
   logic signed [CoordW-1:0] p_x, p_y, q_x, q_y;
   logic [SizeW-1:0]         p_w, p_h, q_w, q_h;
   logic signed [EdgeW-1:0]  p_x2, p_y2, q_x2, q_y2;
   logic signed [EdgeW-1:0]  p_ws, p_hs, q_ws, q_hs;

   always_comb begin
      swap = (func_type'(func) == FUNC_CR);
      p_x = swap ? b_x : a_x;
      p_y = swap ? b_y : a_y;
      p_w = swap ? b_w : a_w;
      p_h = swap ? b_h : a_h;
      q_x = swap ? a_x : b_x;
      q_y = swap ? a_y : b_y;
      q_w = swap ? a_w : b_w;
      q_h = swap ? a_h : b_h;

      p_x2 = EdgeW'($signed({p_x, 1'b0}));
      p_y2 = EdgeW'($signed({p_y, 1'b0}));
      q_x2 = EdgeW'($signed({q_x, 1'b0}));
      q_y2 = EdgeW'($signed({q_y, 1'b0}));
      p_ws = $signed({{(EdgeW-SizeW){1'b0}}, p_w});
      p_hs = $signed({{(EdgeW-SizeW){1'b0}}, p_h});
      q_ws = $signed({{(EdgeW-SizeW){1'b0}}, q_w});
      q_hs = $signed({{(EdgeW-SizeW){1'b0}}, q_h});

      case (func_type'(func))
         FUNC_RR: entry.kind = KIND_RR;
         FUNC_CC: entry.kind = KIND_CC;
         default: entry.kind = KIND_RC;
      endcase
      entry.a_lo_x = p_x2 - p_ws;
      entry.a_hi_x = p_x2 + p_ws;
      entry.a_lo_y = p_y2 - p_hs;
      entry.a_hi_y = p_y2 + p_hs;
      entry.b_lo_x = q_x2 - q_ws;
      entry.b_hi_x = q_x2 + q_ws;
      entry.b_lo_y = q_y2 - q_hs;
      entry.b_hi_y = q_y2 + q_hs;
      entry.a_x    = p_x;
      entry.a_y    = p_y;
      entry.b_x    = q_x;
      entry.b_y    = q_y;
      entry.a_r    = p_w;
      entry.b_r    = q_w;
   end

endmodule

// ----- rtl/spp_queue.sv -----
// Short FIFO between front and back end
module spp_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  spp_pkg::entry_type      wdata,
   input  logic                    pop,
   output spp_pkg::entry_type      rdata,
   output spp_pkg::q_status_type   status
);
   import spp_pkg::*;

   entry_type          mem_ff [QDepth];
   logic [QPtrW-1:0]   wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [QCntW-1:0]   cnt_ff, cnt_in;

   always_comb begin
      wptr_in = push ? QPtrW'(wptr_ff + 1'b1) : wptr_ff;
      rptr_in = pop ? QPtrW'(rptr_ff + 1'b1) : rptr_ff;
      cnt_in  = cnt_ff;
      if (push && !pop) begin
         cnt_in = QCntW'(cnt_ff + 1'b1);
      end else if (pop && !push) begin
         cnt_in = QCntW'(cnt_ff - 1'b1);
      end
      rdata            = mem_ff[rptr_ff];
      status.count     = cnt_ff;
      status.not_empty = (cnt_ff != '0);
      status.full      = (cnt_ff == QCntW'(QDepth));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= wdata;
      end
   end

endmodule

// ----- rtl/spp_sqrt.sv -----
// Pipelined floor square root, two radicand bits per stage
module spp_sqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  logic                       in_valid,
   input  logic [spp_pkg::SqW-1:0]    in_s,
   input  spp_pkg::tag_type           in_tag,
   output logic                       out_valid,
   output logic [spp_pkg::RootW-1:0]  out_root,
   output spp_pkg::tag_type           out_tag
);
   import spp_pkg::*;

   localparam int NStage = RootW;

   logic              vld_ff  [NStage+1];
   logic [SqW-1:0]    s_ff    [NStage+1];
   logic [RemW-1:0]   rem_ff  [NStage+1];
   logic [RootW-1:0]  root_ff [NStage+1];
   tag_type           tag_ff  [NStage+1];

   always_comb begin
      vld_ff[0]  = in_valid;
      s_ff[0]    = in_s;
      rem_ff[0]  = '0;
      root_ff[0] = '0;
      tag_ff[0]  = in_tag;
   end

   for (genvar k = 0; k < NStage; k++) begin : g_stage
      logic [RemW-1:0] trial, t;
      logic            ge;

      always_comb begin
         trial = {rem_ff[k][RemW-3:0], s_ff[k][SqW-1 -: 2]};
         t     = RemW'({root_ff[k], 2'b01});
         ge    = (trial >= t);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (adv) begin
            vld_ff[k+1] <= vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            s_ff[k+1]    <= {s_ff[k][SqW-3:0], 2'b00};
            rem_ff[k+1]  <= ge ? trial - t : trial;
            root_ff[k+1] <= {root_ff[k][RootW-2:0], ge};
            tag_ff[k+1]  <= tag_ff[k];
         end
      end
   end

   assign out_valid = vld_ff[NStage];
   assign out_root  = root_ff[NStage];
   assign out_tag   = tag_ff[NStage];

endmodule

// ----- rtl/spp_back.sv -----
// Back end: overlaps and offsets, squares, compare, square root, result register
module spp_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  spp_pkg::entry_type          in_entry,
   output logic                        adv,
   input  logic                        out_ready,
   output logic                        out_valid,
   output logic                        out_hit,
   output logic [spp_pkg::DepthW-1:0]  out_depth
);
   import spp_pkg::*;

   // stage 1: overlaps, offsets, limit
   logic signed [EdgeW-1:0]  px, py, cx, cy;
   logic signed [OvW-1:0]    ox, oy;
   logic signed [CoordW:0]   cdx, cdy;
   logic [OvW-1:0]           mdx, mdy;
   logic [DepthW-1:0]        lim;

   logic                     v1_ff;
   kind_type                 kind1_ff;
   logic [DepthW-1:0]        dx1_ff, dy1_ff, lim1_ff;
   logic                     far1_ff;
   logic [SizeW-1:0]         rad1_ff;
   logic signed [OvW-1:0]    ox1_ff, oy1_ff;

   // stage 2: squares
   logic                     v2_ff;
   kind_type                 kind2_ff;
   logic [SqW-1:0]           x2_ff, y2_ff, l2_ff;
   logic                     far2_ff;
   logic [DepthW-1:0]        lim2_ff;
   logic [SizeW-1:0]         rad2_ff;
   logic                     rrhit2_ff;
   logic [DepthW-1:0]        rrdep2_ff;
   logic signed [OvW-1:0]    omin;

   // stage 3: sum and compare
   logic                     v3_ff;
   logic [SqW-1:0]           s3_ff;
   tag_type                  tag3_ff;
   logic [SqW:0]             ssum;
   tag_type                  tag3_in;

   logic                     sq_valid;
   logic [RootW-1:0]         sq_root;
   tag_type                  sq_tag;

   logic                     out_valid_ff, out_hit_ff;
   logic [DepthW-1:0]        out_depth_ff, depth_in;

   assign adv = !out_valid_ff || out_ready;

   always_comb begin
      ox = OvW'((in_entry.a_hi_x < in_entry.b_hi_x) ? in_entry.a_hi_x : in_entry.b_hi_x)
         - OvW'((in_entry.a_lo_x > in_entry.b_lo_x) ? in_entry.a_lo_x : in_entry.b_lo_x);
      oy = OvW'((in_entry.a_hi_y < in_entry.b_hi_y) ? in_entry.a_hi_y : in_entry.b_hi_y)
         - OvW'((in_entry.a_lo_y > in_entry.b_lo_y) ? in_entry.a_lo_y : in_entry.b_lo_y);

      cdx = (CoordW+1)'(in_entry.b_x) - (CoordW+1)'(in_entry.a_x);
      cdy = (CoordW+1)'(in_entry.b_y) - (CoordW+1)'(in_entry.a_y);

      // circle centre in Q.17, clamped onto the rectangle
      cx = EdgeW'($signed({in_entry.b_x, 1'b0}));
      cy = EdgeW'($signed({in_entry.b_y, 1'b0}));
      px = (cx < in_entry.a_lo_x) ? in_entry.a_lo_x :
           ((cx > in_entry.a_hi_x) ? in_entry.a_hi_x : cx);
      py = (cy < in_entry.a_lo_y) ? in_entry.a_lo_y :
           ((cy > in_entry.a_hi_y) ? in_entry.a_hi_y : cy);

      case (in_entry.kind)
         KIND_CC: begin
            mdx = mag(OvW'(cdx));
            mdy = mag(OvW'(cdy));
            lim = DepthW'(in_entry.a_r) + DepthW'(in_entry.b_r);
         end
         default: begin
            mdx = mag(OvW'(cx) - OvW'(px));
            mdy = mag(OvW'(cy) - OvW'(py));
            lim = {in_entry.b_r, 1'b0};
         end
      endcase
   end

   always_comb begin
      omin = (ox1_ff < oy1_ff) ? ox1_ff : oy1_ff;
   end

   always_comb begin
      ssum = {1'b0, x2_ff} + {1'b0, y2_ff};
      tag3_in.kind     = kind2_ff;
      tag3_in.hit      = (kind2_ff == KIND_RR) ? rrhit2_ff
                                               : (!far2_ff && (ssum < {1'b0, l2_ff}));
      tag3_in.lim      = lim2_ff;
      tag3_in.radius   = rad2_ff;
      tag3_in.rr_depth = rrdep2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         kind1_ff  <= in_entry.kind;
         dx1_ff    <= mdx[DepthW-1:0];
         dy1_ff    <= mdy[DepthW-1:0];
         lim1_ff   <= lim;
         far1_ff   <= (mdx >= OvW'(lim)) || (mdy >= OvW'(lim));
         rad1_ff   <= in_entry.b_r;
         ox1_ff    <= ox;
         oy1_ff    <= oy;

         kind2_ff  <= kind1_ff;
         x2_ff     <= dx1_ff * dx1_ff;
         y2_ff     <= dy1_ff * dy1_ff;
         l2_ff     <= lim1_ff * lim1_ff;
         far2_ff   <= far1_ff;
         lim2_ff   <= lim1_ff;
         rad2_ff   <= rad1_ff;
         rrhit2_ff <= (ox1_ff > 0) && (oy1_ff > 0);
         rrdep2_ff <= omin[DepthW:1];

         s3_ff     <= ssum[SqW-1:0];
         tag3_ff   <= tag3_in;
      end
   end

   spp_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v3_ff),
      .in_s      (s3_ff),
      .in_tag    (tag3_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_tag   (sq_tag)
   );

   always_comb begin
      depth_in = '0;
      if (sq_tag.hit) begin
         case (sq_tag.kind)
            KIND_RR: depth_in = sq_tag.rr_depth;
            KIND_CC: depth_in = sq_tag.lim - sq_root;
            default: depth_in = DepthW'(sq_tag.radius) - DepthW'(sq_root[RootW-1:1]);
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_hit_ff   <= sq_tag.hit;
         out_depth_ff <= depth_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_hit   = out_hit_ff;
   assign out_depth = out_depth_ff;

endmodule

// ----- rtl/shape_pair_penetration_depth_core.sv -----
// Top level of the shape pair penetration depth core
// Collision test for one pair of centred shapes per item: rect-rect,
// circle-circle, rect-circle or circle-rect (operands swapped into the
// rect-circle test). Each item yields one result, a hit flag and an unsigned
// Q16.16 penetration depth that is zero on a miss. The core takes one item
// per clock and returns one result per clock in steady flow while the response
// side is ready. The accepting edge writes the two-entry queue, then the back
// end takes the item through three back-end stages (overlaps and offsets,
// 32x32 squares, sum and compare), 32 stages of the square root that resolve
// one root bit each, and the result register. A stalled response freezes the
// back end; the queue keeps taking items until it holds two.
module shape_pair_penetration_depth_core (
   input  logic       clock,
   input  logic       reset,
   spp_req_if.sink    req_ch,
   spp_rsp_if.source  rsp_ch
);
   import spp_pkg::*;

   entry_type     front_entry, q_entry;
   q_status_type  q_stat;
   logic          push, pop, back_adv;

   // classify and form edges
   spp_front u_front (
      .func  (req_ch.func),
      .a_x   (req_ch.a_x),
      .a_y   (req_ch.a_y),
      .a_w   (req_ch.a_width_or_radius),
      .a_h   (req_ch.a_height),
      .b_x   (req_ch.b_x),
      .b_y   (req_ch.b_y),
      .b_w   (req_ch.b_width_or_radius),
      .b_h   (req_ch.b_height),
      .entry (front_entry)
   );

   assign req_ch.ready = !q_stat.full;
   assign push         = req_ch.valid && !q_stat.full;
   assign pop          = back_adv && q_stat.not_empty;

   // decouples the front from back-end stalls
   spp_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .wdata  (front_entry),
      .pop    (pop),
      .rdata  (q_entry),
      .status (q_stat)
   );

   spp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_stat.not_empty),
      .in_entry  (q_entry),
      .adv       (back_adv),
      .out_ready (rsp_ch.ready),
      .out_valid (rsp_ch.valid),
      .out_hit   (rsp_ch.hit),
      .out_depth (rsp_ch.depth)
   );

`include "shape_pair_penetration_depth_core_defines.svh"

   // a miss always reports zero depth
   `SPP_ASSERT_IMP(a_miss_zero, clock, reset, rsp_ch.valid && !rsp_ch.hit, rsp_ch.depth == '0)
   // queue never holds more than its depth
   `SPP_ASSERT_IMP(a_q_bound, clock, reset, 1'b1, q_stat.count <= QCntW'(QDepth))
   // a push without a pop grows the queue by one
   `SPP_ASSERT_NEXT(a_q_grow, clock, reset, push && !pop, q_stat.count == QCntW'($past(q_stat.count) + 1'b1))

endmodule

// ----- test/spp_tb_ifs.sv -----
// Item and result types used by the testbench scoreboard
package spp_tb_types;
   import spp_pkg::*;

   typedef struct {
      logic [1:0]                func;
      logic signed [CoordW-1:0]  a_x;
      logic signed [CoordW-1:0]  a_y;
      logic [SizeW-1:0]          a_w;
      logic [SizeW-1:0]          a_h;
      logic signed [CoordW-1:0]  b_x;
      logic signed [CoordW-1:0]  b_y;
      logic [SizeW-1:0]          b_w;
      logic [SizeW-1:0]          b_h;
   } pair_type;

   typedef struct {
      logic               hit;
      logic [DepthW-1:0]  depth;
   } contact_type;
endpackage

// ----- test/testbench.sv -----
// Self-checking testbench for the shape pair penetration depth core
module testbench;
   import spp_pkg::*;
   import spp_tb_types::*;

   // floor square root of a 64-bit value, bit by bit
   function automatic logic [63:0] floor_root(input logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic logic [63:0] abs64(input longint v);
      return v < 0 ? 64'(-v) : 64'(v);
   endfunction

   // squared length, false when an offset reaches lim or the sum wraps
   function automatic bit square_len(input logic [63:0] dx, input logic [63:0] dy,
                                     input logic [63:0] lim, output logic [63:0] s);
      logic [63:0] x2;
      logic [63:0] y2;
      s = 0;
      if (dx >= lim || dy >= lim) return 0;
      x2 = dx * dx;
      y2 = dy * dy;
      s = x2 + y2;
      return s >= x2;
   endfunction

   // rectangle (rx,ry,rw,rh) against circle (cx0,cy0,cr), Q.17 edges
   function automatic bit rect_vs_circle(input longint rx, input longint ry,
         input longint rw, input longint rh, input longint cx0, input longint cy0,
         input longint cr, output logic [63:0] dep);
      longint cx;
      longint cy;
      longint px;
      longint py;
      logic [63:0] r2;
      logic [63:0] s;
      dep = 0;
      cx = 2 * cx0;
      cy = 2 * cy0;
      px = cx < 2 * rx - rw ? 2 * rx - rw : (cx > 2 * rx + rw ? 2 * rx + rw : cx);
      py = cy < 2 * ry - rh ? 2 * ry - rh : (cy > 2 * ry + rh ? 2 * ry + rh : cy);
      r2 = 2 * 64'(cr);
      if (!square_len(abs64(cx - px), abs64(cy - py), r2, s)) return 0;
      if (s >= r2 * r2) return 0;
      dep = 64'(cr) - (floor_root(s) >> 1);
      return 1;
   endfunction

   function automatic contact_type predict_contact(input pair_type it);
      contact_type r;
      longint ax, ay, aw, ah, bx, by, bw, bh;
      longint ox, oy, m;
      logic [63:0] rs, s, dep;
      bit hit;
      ax = it.a_x; ay = it.a_y; aw = it.a_w; ah = it.a_h;
      bx = it.b_x; by = it.b_y; bw = it.b_w; bh = it.b_h;
      dep = 0;
      hit = 0;
      case (func_type'(it.func))
         FUNC_RR: begin
            ox = ((2*ax+aw) < (2*bx+bw) ? 2*ax+aw : 2*bx+bw)
               - ((2*ax-aw) > (2*bx-bw) ? 2*ax-aw : 2*bx-bw);
            oy = ((2*ay+ah) < (2*by+bh) ? 2*ay+ah : 2*by+bh)
               - ((2*ay-ah) > (2*by-bh) ? 2*ay-ah : 2*by-bh);
            if (ox > 0 && oy > 0) begin
               hit = 1;
               m = ox < oy ? ox : oy;
               dep = 64'(m) >> 1;
            end
         end
         FUNC_CC: begin
            rs = 64'(aw) + 64'(bw);
            if (square_len(abs64(bx - ax), abs64(by - ay), rs, s) && s < rs * rs) begin
               hit = 1;
               dep = rs - floor_root(s);
            end
         end
         FUNC_RC: hit = rect_vs_circle(ax, ay, aw, ah, bx, by, bw, dep);
         default: hit = rect_vs_circle(bx, by, bw, bh, ax, ay, aw, dep);
      endcase
      if (!hit) dep = 0;
      if (dep > 64'hFFFF_FFFF) dep = 64'hFFFF_FFFF;
      r.hit = hit;
      r.depth = dep[31:0];
      return r;
   endfunction

   class contact_scoreboard;
      contact_type pending[$];
      int errors;

      function void note_pair(input pair_type it);
         pending.push_back(predict_contact(it));
      endfunction

      function void check_contact(input logic hit, input logic [DepthW-1:0] depth);
         contact_type e;
         if (pending.size() == 0) begin
            $error("unexpected result hit=%0d depth=%h", hit, depth);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (hit !== e.hit) begin
            $error("hit: expected %0d actual %0d", e.hit, hit);
            errors++;
         end
         if (depth !== e.depth) begin
            $error("depth: expected %h actual %h", e.depth, depth);
            errors++;
         end
      endfunction
   endclass

   localparam int RandomPairs = 550;
   localparam int StallLimit = 20000;
   localparam int Latency = 37;

   logic clock = 0;
   logic reset = 1;
   always #5 clock = ~clock;

   spp_req_if req_ch();
   spp_rsp_if rsp_ch();

   shape_pair_penetration_depth_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   contact_scoreboard board = new();
   pair_type directed[$];
   bit calm = 0;        // no idling on either side
   bit hold_off = 0;    // long receiver stall requested
   int quiet_cycles = 0;

   initial begin
      req_ch.valid = 0;
      req_ch.func = 0;
      req_ch.a_x = 0;
      req_ch.a_y = 0;
      req_ch.a_width_or_radius = 0;
      req_ch.a_height = 0;
      req_ch.b_x = 0;
      req_ch.b_y = 0;
      req_ch.b_width_or_radius = 0;
      req_ch.b_height = 0;
      rsp_ch.ready = 0;
   end

   // scoreboard side: note accepted pairs, check accepted results
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            pair_type it;
            it.func = req_ch.func;
            it.a_x = req_ch.a_x;
            it.a_y = req_ch.a_y;
            it.a_w = req_ch.a_width_or_radius;
            it.a_h = req_ch.a_height;
            it.b_x = req_ch.b_x;
            it.b_y = req_ch.b_y;
            it.b_w = req_ch.b_width_or_radius;
            it.b_h = req_ch.b_height;
            board.note_pair(it);
         end
         if (rsp_ch.valid && rsp_ch.ready)
            board.check_contact(rsp_ch.hit, rsp_ch.depth);
         // watchdog on handshakes
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= StallLimit) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // receiver: random stalls, one long hold-off when asked
   initial begin : receiver
      int hold;
      hold = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off && hold == 0) begin
            hold = 300;
            hold_off = 0;
         end
         if (hold > 0) begin
            hold--;
            rsp_ch.ready <= 0;
         end else begin
            rsp_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 11);
         end
      end
   end

   function automatic logic [SizeW-1:0] rand_size();
      case ($urandom_range(3))
         0: return SizeW'($urandom_range(65535));
         1: return SizeW'($urandom) & 31'h00FF_FFFF;
         2: return SizeW'($urandom);
         default: return SizeW'($urandom_range(3)) << 16;
      endcase
   endfunction

   function automatic logic signed [CoordW-1:0] near(input logic signed [CoordW-1:0] c);
      case ($urandom_range(2))
         0: return c + CoordW'($signed($urandom_range(65535) << 4) - 32'sh80000);
         1: return c + CoordW'($signed($urandom) >>> 8);
         default: return $urandom;
      endcase
   endfunction

   function automatic pair_type rand_pair();
      pair_type it;
      it.func = 2'($urandom_range(3));
      it.a_x = ($urandom_range(9) == 0) ? $urandom : CoordW'($signed($urandom) >>> 6);
      it.a_y = ($urandom_range(9) == 0) ? $urandom : CoordW'($signed($urandom) >>> 6);
      it.b_x = near(it.a_x);
      it.b_y = near(it.a_y);
      it.a_w = rand_size();
      it.a_h = rand_size();
      it.b_w = rand_size();
      it.b_h = rand_size();
      return it;
   endfunction

   function automatic pair_type make_pair(input func_type f,
         input logic signed [31:0] ax, input logic signed [31:0] ay,
         input logic [30:0] aw, input logic [30:0] ah,
         input logic signed [31:0] bx, input logic signed [31:0] by,
         input logic [30:0] bw, input logic [30:0] bh);
      pair_type it;
      it.func = f;
      it.a_x = ax; it.a_y = ay; it.a_w = aw; it.a_h = ah;
      it.b_x = bx; it.b_y = by; it.b_w = bw; it.b_h = bh;
      return it;
   endfunction

   // offer one pair and hold it until accepted
   task automatic send_pair(input pair_type it);
      req_ch.valid <= 1;
      req_ch.func <= it.func;
      req_ch.a_x <= it.a_x;
      req_ch.a_y <= it.a_y;
      req_ch.a_width_or_radius <= it.a_w;
      req_ch.a_height <= it.a_h;
      req_ch.b_x <= it.b_x;
      req_ch.b_y <= it.b_y;
      req_ch.b_width_or_radius <= it.b_w;
      req_ch.b_height <= it.b_h;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic idle_gap();
      while (!calm && $urandom_range(99) < 11) begin
         req_ch.valid <= 0;
         @(posedge clock);
      end
   endtask

   initial begin : sender
      localparam logic signed [31:0] MaxC = 32'sh7FFF_FFFF;
      localparam logic signed [31:0] MinC = 32'sh8000_0000;
      localparam logic [30:0] MaxS = 31'h7FFF_FFFF;
      localparam logic [30:0] One = 31'h1_0000;
      int waited;
      // extremes, every pair kind, touching edges, half-LSB overlap, zero sizes
      directed.push_back(make_pair(FUNC_RR, 0, 0, 2*One, 2*One, One, One, 2*One, 2*One));
      directed.push_back(make_pair(FUNC_RR, 0, 0, 2*One, 2*One, 2*One, 0, 2*One, 2*One));
      directed.push_back(make_pair(FUNC_RR, 0, 0, 1, 1, 0, 0, 0, 0));
      directed.push_back(make_pair(FUNC_RR, 0, 0, 1, 1, 1, 0, 1, 1));
      directed.push_back(make_pair(FUNC_RR, MaxC, MinC, MaxS, MaxS, MinC, MaxC, MaxS, MaxS));
      directed.push_back(make_pair(FUNC_RR, MaxC, MaxC, MaxS, MaxS, MaxC, MaxC, MaxS, MaxS));
      directed.push_back(make_pair(FUNC_CC, 0, 0, One, 0, One, 0, One, 0));
      directed.push_back(make_pair(FUNC_CC, 0, 0, 2*One, 0, 2*One, 0, 0, 0));
      directed.push_back(make_pair(FUNC_CC, 5, 5, 0, 0, 5, 5, 0, 0));
      directed.push_back(make_pair(FUNC_CC, 0, 0, One, 0, 3*One, 4*One, 5*One, 0));
      directed.push_back(make_pair(FUNC_CC, MaxC, MaxC, MaxS, MaxS, MinC, MinC, MaxS, MaxS));
      directed.push_back(make_pair(FUNC_CC, MaxC, MinC, MaxS, 0, MaxC, MinC, MaxS, 0));
      directed.push_back(make_pair(FUNC_RC, 0, 0, 2*One, 2*One, 2*One, 0, One, 0));
      directed.push_back(make_pair(FUNC_RC, 0, 0, 2*One, 2*One, 0, 0, 0, MaxS));
      directed.push_back(make_pair(FUNC_RC, 0, 0, 2*One, 2*One, 2*One, 2*One, One, 0));
      directed.push_back(make_pair(FUNC_RC, MinC, MinC, MaxS, MaxS, MaxC, MaxC, MaxS, MaxS));
      directed.push_back(make_pair(FUNC_RC, MaxC, MaxC, 0, 0, MaxC, MaxC, MaxS, 0));
      directed.push_back(make_pair(FUNC_CR, 3*One, 0, One, MaxS, 0, 0, 2*One, 2*One));
      directed.push_back(make_pair(FUNC_CR, 0, 0, 0, 0, 0, 0, 2*One, 2*One));
      directed.push_back(make_pair(FUNC_CR, MinC, MaxC, MaxS, MaxS, MaxC, MinC, MaxS, MaxS));
      directed.push_back(make_pair(FUNC_CR, 32'shFFFF_FFFF, 1, 31'h5555_5555, 0,
                                   1, 32'shFFFF_FFFF, 31'h2AAA_AAAA, 31'h5555_5555));
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      foreach (directed[i]) begin
         idle_gap();
         send_pair(directed[i]);
      end
      for (int n = 0; n < RandomPairs; n++) begin
         if (n == 150) calm = 1;        // long stretch without idling
         if (n == 250) calm = 0;
         if (n == 350) hold_off = 1;    // back end fills, input stalls
         idle_gap();
         send_pair(rand_pair());
      end
      req_ch.valid <= 0;
      waited = 0;
      while (board.pending.size() != 0 && waited < StallLimit) begin
         @(posedge clock);
         waited++;
      end
      repeat (2 * Latency) @(posedge clock);
      if (board.pending.size() == 0 && board.errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule

// ----- shape_pair_penetration_depth_core.f -----
+incdir+rtl
rtl/spp_pkg.sv
rtl/spp_ifs.sv
rtl/spp_front.sv
rtl/spp_queue.sv
rtl/spp_sqrt.sv
rtl/spp_back.sv
rtl/shape_pair_penetration_depth_core.sv
test/spp_tb_ifs.sv
test/testbench.sv
